[sv/bilinear_calibration_map_assert.svh]
// Assertion macros for the bilinear calibration map
`ifndef BILINEAR_CALIBRATION_MAP_ASSERT_SVH
`define BILINEAR_CALIBRATION_MAP_ASSERT_SVH
// same-cycle implication
`define BCM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define BCM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

[sv/bcm_pkg.sv]
// Shared codes, state types and constants of the bilinear calibration map
`timescale 1ns / 1ps
package bcm_pkg;
	localparam int FRAC_BITS = 16;
	localparam logic [16:0] FRAC_ONE = 17'h10000;
	localparam logic [4:0] BLEND_CYCLES = 5'd18;

	typedef enum logic [1:0] {OP_LOOKUP, OP_CELL, OP_XPT, OP_YPT} op_t;
	typedef enum logic [1:0] {ST_OK, ST_INDEX, ST_LIMIT} status_t;
	typedef enum logic [1:0] {
		REG_COL_COUNT, REG_ROW_COUNT, REG_LOW_LIMIT, REG_HIGH_LIMIT
	} reg_t;
	typedef enum logic [2:0] {L_IDLE, L_RD0, L_RDN, L_CHKN, L_SCAN, L_DIV} loc_state_t;
	typedef enum logic [2:0] {S_IDLE, S_LOC, S_RD, S_BL1, S_BL2, S_OUT} seq_state_t;
endpackage

[sv/bilinear_calibration_map.sv]
// Top level of the bilinear calibration map: registers, grid store, sequencer
//
//   channel | direction | words
//   --------+-----------+-----------------------------------------------
//   in      | in        | op, row_index, col_index, cell_value, query_x/y
//   out     | out       | result_value, status
//   cfg     | in        | cfg_index, cfg_data
//
// A write goes through S_OUT to the output register, waiting while the output is held; input reopens as it loads.
// A lookup scans both axes in parallel, one point per cycle, each followed by a serial
// fraction divide when the query falls inside the axis, then reads the four corner cells
// from the grid and blends them in two phases before its word reaches the output register.
// Reset clears control state; axis points and cells hold nothing until written.
// A new word is taken once the previous result sits in the output register.
`timescale 1ns / 1ps
`include "bilinear_calibration_map_assert.svh"
module bilinear_calibration_map #(
	parameter int AXIS_POINTS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         op,
	input  logic [3:0]         row_index,
	input  logic [3:0]         col_index,
	input  logic signed [31:0] cell_value,
	input  logic signed [31:0] query_x,
	input  logic signed [31:0] query_y,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] result_value,
	output logic [1:0]         status,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	localparam int AW = $clog2(AXIS_POINTS);
	localparam int CW = $clog2(AXIS_POINTS + 1);
	localparam int KW = (CW > 4) ? CW : 4;
	localparam int DEPTH = 1 << (2 * AW);

	bcm_pkg::seq_state_t state_q, state_d;
	logic [CW-1:0]      col_count_q, row_count_q, cfg_count;
	logic signed [31:0] low_q, high_q;
	logic               acc_in, cfg_we;
	logic               row_ok, col_ok, val_ok;
	logic               cell_we, x_we, y_we, loc_start;
	logic [1:0]         wstat;
	logic               xl_busy, yl_busy;
	logic [AW-1:0]      x_cell, y_cell;
	logic [16:0]        x_frac, y_frac;
	logic signed [31:0] cells [DEPTH];
	logic [2*AW-1:0]    waddr, raddr;
	logic signed [31:0] rd_q;
	logic signed [31:0] corner_q [4];
	logic [2:0]         rc_q;
	logic               bl_start, fin_start;
	logic               b0_busy, b1_busy;
	logic signed [31:0] b0_res, b1_res;
	logic signed [31:0] b0_a, b0_b;
	logic [16:0]        b0_f;
	logic signed [31:0] res_q;
	logic [1:0]         stat_q;
	logic               out_valid_q;
	logic signed [31:0] result_value_q;
	logic [1:0]         status_q;

	assign in_ready     = state_q == bcm_pkg::S_IDLE;
	assign cfg_ready    = 1'b1;
	assign acc_in       = in_valid && in_ready;
	assign cfg_we       = cfg_valid && cfg_ready;
	assign out_valid    = out_valid_q;
	assign result_value = result_value_q;
	assign status       = status_q;

	always_comb begin
		if (cfg_data[4:0] < 5'd2) begin
			cfg_count = CW'(2);
		end else if (32'(cfg_data[4:0]) > 32'(AXIS_POINTS)) begin
			cfg_count = CW'(AXIS_POINTS);
		end else begin
			cfg_count = CW'(cfg_data[4:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_count_q <= CW'(2);
			row_count_q <= CW'(2);
			low_q       <= 32'sh8000_0000;
			high_q      <= 32'sh7fff_ffff;
		end else if (cfg_we) begin
			unique case (bcm_pkg::reg_t'(cfg_index))
				bcm_pkg::REG_COL_COUNT:  col_count_q <= cfg_count;
				bcm_pkg::REG_ROW_COUNT:  row_count_q <= cfg_count;
				bcm_pkg::REG_LOW_LIMIT:  low_q <= cfg_data;
				bcm_pkg::REG_HIGH_LIMIT: high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign row_ok = KW'(row_index) < KW'(row_count_q);
	assign col_ok = KW'(col_index) < KW'(col_count_q);
	assign val_ok = (cell_value >= low_q) && (cell_value <= high_q);

	assign cell_we   = acc_in && (op == bcm_pkg::OP_CELL) && row_ok && col_ok && val_ok;
	assign x_we      = acc_in && (op == bcm_pkg::OP_XPT) && col_ok;
	assign y_we      = acc_in && (op == bcm_pkg::OP_YPT) && row_ok;
	assign loc_start = acc_in && (op == bcm_pkg::OP_LOOKUP);

	always_comb begin
		wstat = bcm_pkg::ST_OK;
		unique case (bcm_pkg::op_t'(op))
			bcm_pkg::OP_CELL: begin
				if (!row_ok || !col_ok) wstat = bcm_pkg::ST_INDEX;
				else if (!val_ok) wstat = bcm_pkg::ST_LIMIT;
			end
			bcm_pkg::OP_XPT: if (!col_ok) wstat = bcm_pkg::ST_INDEX;
			bcm_pkg::OP_YPT: if (!row_ok) wstat = bcm_pkg::ST_INDEX;
			default: wstat = bcm_pkg::ST_OK;
		endcase
	end

	bcm_locate #(.AP(AXIS_POINTS), .AW(AW), .CW(CW)) u_loc_x (
		.clk(clk), .arst_n(arst_n),
		.we(x_we), .waddr(AW'(col_index)), .wdata(cell_value),
		.start(loc_start), .count(col_count_q), .query(query_x),
		.busy(xl_busy), .cell_idx(x_cell), .frac(x_frac)
	);

	bcm_locate #(.AP(AXIS_POINTS), .AW(AW), .CW(CW)) u_loc_y (
		.clk(clk), .arst_n(arst_n),
		.we(y_we), .waddr(AW'(row_index)), .wdata(cell_value),
		.start(loc_start), .count(row_count_q), .query(query_y),
		.busy(yl_busy), .cell_idx(y_cell), .frac(y_frac)
	);

	assign waddr = {AW'(row_index), AW'(col_index)};
	assign raddr = {y_cell + AW'(rc_q[1]), x_cell + AW'(rc_q[0])};

	always_ff @(posedge clk) begin
		if (cell_we) cells[waddr] <= cell_value;
		rd_q <= cells[raddr];
	end

	always_ff @(posedge clk) begin
		if (state_q == bcm_pkg::S_RD && rc_q != 3'd0 && rc_q <= 3'd4) begin
			corner_q[2'(rc_q - 3'd1)] <= rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bcm_pkg::S_IDLE;
			rc_q    <= '0;
		end else begin
			state_q <= state_d;
			rc_q    <= (state_q == bcm_pkg::S_RD) ? rc_q + 3'd1 : 3'd0;
		end
	end

	always_comb begin
		state_d   = state_q;
		bl_start  = 1'b0;
		fin_start = 1'b0;
		unique case (state_q)
			bcm_pkg::S_IDLE: begin
				if (acc_in) begin
					state_d = (op == bcm_pkg::OP_LOOKUP) ? bcm_pkg::S_LOC : bcm_pkg::S_OUT;
				end
			end
			bcm_pkg::S_LOC: if (!xl_busy && !yl_busy) state_d = bcm_pkg::S_RD;
			bcm_pkg::S_RD: begin
				if (rc_q == 3'd5) begin
					bl_start = 1'b1;
					state_d  = bcm_pkg::S_BL1;
				end
			end
			bcm_pkg::S_BL1: begin
				if (!b0_busy && !b1_busy) begin
					fin_start = 1'b1;
					state_d   = bcm_pkg::S_BL2;
				end
			end
			bcm_pkg::S_BL2: if (!b0_busy) state_d = bcm_pkg::S_OUT;
			bcm_pkg::S_OUT: if (!out_valid_q || out_ready) state_d = bcm_pkg::S_IDLE;
			default: state_d = bcm_pkg::S_IDLE;
		endcase
	end

	assign b0_a = fin_start ? b0_res : corner_q[0];
	assign b0_b = fin_start ? b1_res : corner_q[1];
	assign b0_f = fin_start ? y_frac : x_frac;

	bcm_blend u_blend0 (
		.clk(clk), .arst_n(arst_n), .start(bl_start || fin_start),
		.a(b0_a), .b(b0_b), .f(b0_f), .busy(b0_busy), .result(b0_res)
	);

	bcm_blend u_blend1 (
		.clk(clk), .arst_n(arst_n), .start(bl_start),
		.a(corner_q[2]), .b(corner_q[3]), .f(x_frac), .busy(b1_busy), .result(b1_res)
	);

	always_ff @(posedge clk) begin
		if (acc_in) begin
			res_q  <= '0;
			stat_q <= wstat;
		end else if (state_q == bcm_pkg::S_BL2 && !b0_busy) begin
			res_q  <= b0_res;
			stat_q <= bcm_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == bcm_pkg::S_OUT && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == bcm_pkg::S_OUT && (!out_valid_q || out_ready)) begin
			result_value_q <= res_q;
			status_q       <= stat_q;
		end
	end

	`BCM_ASSERT_NEXT(a_write_to_out, acc_in && op != bcm_pkg::OP_LOOKUP, state_q == bcm_pkg::S_OUT, "write word did not go straight to output")
	`BCM_ASSERT_NOW(a_blend_quiet, state_q == bcm_pkg::S_LOC, !b0_busy && !b1_busy, "blend busy during axis search")
	`BCM_ASSERT_NOW(a_locate_quiet, state_q == bcm_pkg::S_IDLE, !xl_busy && !yl_busy, "axis search busy while idle")
	`BCM_ASSERT_NEXT(a_out_load, state_q == bcm_pkg::S_OUT && (!out_valid_q || out_ready), out_valid_q, "output register not loaded")
endmodule

[sv/bcm_locate.sv]
// Axis store, breakpoint scan and bit-serial fraction divider for one axis
`timescale 1ns / 1ps
module bcm_locate #(
	parameter int AP = 16,
	parameter int AW = 4,
	parameter int CW = 5
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  logic signed [31:0]   wdata,
	input  logic                 start,
	input  logic [CW-1:0]        count,
	input  logic signed [31:0]   query,
	output logic                 busy,
	output logic [AW-1:0]        cell_idx,
	output logic [16:0]          frac
);
	logic signed [31:0] pts [AP];
	logic signed [31:0] rdata_q;
	logic signed [31:0] v_q;
	logic signed [31:0] lo_q;
	logic signed [33:0] rem_q;
	logic signed [33:0] span_q;
	logic signed [33:0] span_now;
	logic signed [33:0] rem2;
	logic               ge;
	logic               pass;
	logic [14:0]        quo_q;
	logic [3:0]         bit_q;
	logic [AW-1:0]      k_q;
	logic [AW-1:0]      last;
	logic [AW-1:0]      raddr;
	logic [AW-1:0]      cell_q;
	logic [16:0]        frac_q;
	bcm_pkg::loc_state_t state_q, state_d;

	assign last     = AW'(count - 1'b1);
	assign span_now = 34'(rdata_q) - 34'(lo_q);
	assign pass     = (k_q != last) && (rdata_q <= v_q);
	assign rem2     = rem_q <<< 1;
	assign ge       = rem2 >= span_q;
	assign busy     = state_q != bcm_pkg::L_IDLE;
	assign cell_idx = cell_q;
	assign frac     = frac_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bcm_pkg::L_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		raddr   = '0;
		unique case (state_q)
			bcm_pkg::L_IDLE: begin
				if (start) state_d = bcm_pkg::L_RD0;
			end
			bcm_pkg::L_RD0: begin
				state_d = bcm_pkg::L_RDN;
			end
			bcm_pkg::L_RDN: begin
				raddr   = last;
				state_d = (v_q <= rdata_q) ? bcm_pkg::L_IDLE : bcm_pkg::L_CHKN;
			end
			bcm_pkg::L_CHKN: begin
				raddr   = k_q;
				state_d = (v_q >= rdata_q) ? bcm_pkg::L_IDLE : bcm_pkg::L_SCAN;
			end
			bcm_pkg::L_SCAN: begin
				if (pass) begin
					raddr = k_q + 1'b1;
				end else begin
					state_d = (span_now > 0) ? bcm_pkg::L_DIV : bcm_pkg::L_IDLE;
				end
			end
			bcm_pkg::L_DIV: begin
				if (bit_q == 4'd0) state_d = bcm_pkg::L_IDLE;
			end
			default: state_d = bcm_pkg::L_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) pts[waddr] <= wdata;
		rdata_q <= pts[raddr];
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			bcm_pkg::L_IDLE: begin
				if (start) begin
					v_q <= query;
					k_q <= AW'(1);
				end
			end
			bcm_pkg::L_RDN: begin
				lo_q <= rdata_q;
				if (v_q <= rdata_q) begin
					cell_q <= '0;
					frac_q <= '0;
				end
			end
			bcm_pkg::L_CHKN: begin
				if (v_q >= rdata_q) begin
					cell_q <= last - 1'b1;
					frac_q <= bcm_pkg::FRAC_ONE;
				end
			end
			bcm_pkg::L_SCAN: begin
				if (pass) begin
					lo_q <= rdata_q;
					k_q  <= k_q + 1'b1;
				end else begin
					cell_q <= k_q - 1'b1;
					frac_q <= '0;
					rem_q  <= 34'(v_q) - 34'(lo_q);
					span_q <= span_now;
					bit_q  <= 4'(bcm_pkg::FRAC_BITS - 1);
				end
			end
			bcm_pkg::L_DIV: begin
				rem_q <= ge ? rem2 - span_q : rem2;
				quo_q <= {quo_q[13:0], ge};
				bit_q <= bit_q - 1'b1;
				if (bit_q == 4'd0) frac_q <= {1'b0, quo_q, ge};
			end
			default: ;
		endcase
	end
endmodule

[sv/bcm_blend.sv]
// Shift-add blend of two values by a Q1.16 fraction, truncating toward zero
`timescale 1ns / 1ps
module bcm_blend (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [31:0]  a,
	input  logic signed [31:0]  b,
	input  logic [16:0]         f,
	output logic                busy,
	output logic signed [31:0]  result
);
	logic signed [51:0] acc_q;
	logic signed [51:0] m_q;
	logic signed [51:0] quot;
	logic [16:0]        f_q;
	logic [4:0]         cnt_q;
	logic signed [31:0] result_q;

	assign busy   = cnt_q != 5'd0;
	assign result = result_q;
	assign quot   = acc_q >>> bcm_pkg::FRAC_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= bcm_pkg::BLEND_CYCLES;
		end else if (cnt_q != 5'd0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= 52'(a) <<< bcm_pkg::FRAC_BITS;
			m_q   <= 52'(b) - 52'(a);
			f_q   <= f;
		end else if (cnt_q > 5'd1) begin
			if (f_q[0]) acc_q <= acc_q + m_q;
			m_q <= m_q <<< 1;
			f_q <= f_q >> 1;
		end else if (cnt_q == 5'd1) begin
			if (acc_q[51] && (acc_q[15:0] != 16'd0)) begin
				result_q <= 32'(quot + 52'sd1);
			end else begin
				result_q <= 32'(quot);
			end
		end
	end
endmodule
